/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RRF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define RRF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`RRF_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define RRF_ASSERT(lbl, clk, rst_n, prop)

`define RRF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/rrf_pkg.sv */
`timescale 1ns / 1ps

package rrf_pkg;

	localparam int FB_WIDTH  = 1024;
	localparam int FB_HEIGHT = 1024;

	localparam int PIX_W       = 10;
	localparam int COORD_W     = 13;
	localparam int RADIUS_W    = 12;
	localparam int RADIUS_SQ_W = 2 * RADIUS_W;
	localparam int MASK_W      = 4;
	localparam int COLOR_W     = 32;
	localparam int ADDR_W      = 20;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_RECT_LEFT     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RECT_TOP      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RECT_RIGHT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RECT_BOTTOM   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CORNER_RADIUS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CORNER_MASK   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR    = 3'd6;

	localparam logic [MASK_W-1:0] CORNER_MASK_RESET = 4'hF;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic signed [COORD_W-1:0] rect_right;
		logic signed [COORD_W-1:0] rect_bottom;
		logic [RADIUS_W-1:0]       corner_radius;
		logic [RADIUS_SQ_W-1:0]    radius_sq;
		logic [MASK_W-1:0]         corner_mask;
		logic [COLOR_W-1:0]        fill_color;
	} cfg_t;

endpackage

/* hw/rtl/rrf_cfg.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrf_cfg
	import rrf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	logic signed [COORD_W-1:0] left_q;
	logic signed [COORD_W-1:0] top_q;
	logic signed [COORD_W-1:0] right_q;
	logic signed [COORD_W-1:0] bottom_q;
	logic [RADIUS_W-1:0]       radius_q;
	logic [RADIUS_SQ_W-1:0]    radius_sq_q;
	logic [MASK_W-1:0]         mask_q;
	logic [COLOR_W-1:0]        color_q;
	logic [RADIUS_W-1:0]       radius_in;
	logic                      wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign radius_in = cfg_data[RADIUS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			top_q       <= '0;
			right_q     <= '0;
			bottom_q    <= '0;
			radius_q    <= '0;
			radius_sq_q <= '0;
			mask_q      <= CORNER_MASK_RESET;
			color_q     <= '0;
		end else if (wr) begin
			case (cfg_index)
				REG_RECT_LEFT:     left_q   <= cfg_data[COORD_W-1:0];
				REG_RECT_TOP:      top_q    <= cfg_data[COORD_W-1:0];
				REG_RECT_RIGHT:    right_q  <= cfg_data[COORD_W-1:0];
				REG_RECT_BOTTOM:   bottom_q <= cfg_data[COORD_W-1:0];
				REG_CORNER_RADIUS: begin
					// The square is kept beside the radius so the pixel path only
					// has to square the corner offsets.
					radius_q    <= radius_in;
					radius_sq_q <= radius_in * radius_in;
				end
				REG_CORNER_MASK:   mask_q   <= cfg_data[MASK_W-1:0];
				REG_FILL_COLOR:    color_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.rect_left     = left_q;
		cfg.rect_top      = top_q;
		cfg.rect_right    = right_q;
		cfg.rect_bottom   = bottom_q;
		cfg.corner_radius = radius_q;
		cfg.radius_sq     = radius_sq_q;
		cfg.corner_mask   = mask_q;
		cfg.fill_color    = color_q;
	end

	`RRF_ASSERT(a_radius_sq_tracks, clk, arst_n, (wr && cfg_index == REG_CORNER_RADIUS) |=> (radius_sq_q == $past(radius_in) * $past(radius_in)))
	`RRF_ASSERT(a_radius_sq_holds, clk, arst_n, (!wr || cfg_index != REG_CORNER_RADIUS) |=> $stable(radius_sq_q))
	`RRF_ASSERT(a_unknown_index_ignored, clk, arst_n, (wr && cfg_index > REG_FILL_COLOR) |=> $stable(cfg))

endmodule

/* hw/rtl/rrf_cover.sv */
`timescale 1ns / 1ps

module rrf_cover
	import rrf_pkg::*;
(
	input  cfg_t cfg,
	input  pix_t pix,
	output res_t res
);

	localparam int SW     = COORD_W + 2;
	localparam int DIM_W  = 14;
	localparam int SUM_W  = RADIUS_SQ_W + 1;
	localparam int MUL_W  = DIM_W + DIM_W;

	logic signed [SW-1:0] xs, ys, l_e, t_e, rt_e, b_e, r_e;
	logic signed [SW-1:0] dl, dr, dt, db;
	logic signed [SW-1:0] ml, mr, mt, mb;
	logic [RADIUS_SQ_W-1:0] sq_l, sq_r, sq_t, sq_b;
	logic [SUM_W-1:0] sum_tl, sum_tr, sum_bl, sum_br, rsq_e;
	logic x_in_fb, y_in_fb, in_rect;
	logic near_l, near_r, near_t, near_b;
	logic drop_tl, drop_tr, drop_bl, drop_br, cov;
	logic [MUL_W-1:0] addr_full;

	assign xs   = {{(SW-PIX_W){1'b0}}, pix.pixel_x};
	assign ys   = {{(SW-PIX_W){1'b0}}, pix.pixel_y};
	assign l_e  = {{(SW-COORD_W){cfg.rect_left[COORD_W-1]}}, cfg.rect_left};
	assign t_e  = {{(SW-COORD_W){cfg.rect_top[COORD_W-1]}}, cfg.rect_top};
	assign rt_e = {{(SW-COORD_W){cfg.rect_right[COORD_W-1]}}, cfg.rect_right};
	assign b_e  = {{(SW-COORD_W){cfg.rect_bottom[COORD_W-1]}}, cfg.rect_bottom};
	assign r_e  = {{(SW-RADIUS_W){1'b0}}, cfg.corner_radius};

	// Distances of the pixel from each edge; all are non-negative inside the rectangle.
	assign dl = xs - l_e;
	assign dr = rt_e - xs - SW'(1);
	assign dt = ys - t_e;
	assign db = b_e - ys - SW'(1);

	assign x_in_fb = {{(DIM_W-PIX_W){1'b0}}, pix.pixel_x} < DIM_W'(FB_WIDTH);
	assign y_in_fb = {{(DIM_W-PIX_W){1'b0}}, pix.pixel_y} < DIM_W'(FB_HEIGHT);
	assign in_rect = (dl >= 0) && (dr >= 0) && (dt >= 0) && (db >= 0) && x_in_fb && y_in_fb;

	assign near_l = dl < r_e;
	assign near_r = dr < r_e;
	assign near_t = dt < r_e;
	assign near_b = db < r_e;

	// Inside a corner square the offset from the arc center has magnitude
	// radius minus edge distance, which lies between one and the radius.
	assign ml = r_e - dl;
	assign mr = r_e - dr;
	assign mt = r_e - dt;
	assign mb = r_e - db;

	assign sq_l = ml[RADIUS_W-1:0] * ml[RADIUS_W-1:0];
	assign sq_r = mr[RADIUS_W-1:0] * mr[RADIUS_W-1:0];
	assign sq_t = mt[RADIUS_W-1:0] * mt[RADIUS_W-1:0];
	assign sq_b = mb[RADIUS_W-1:0] * mb[RADIUS_W-1:0];

	assign sum_tl = {1'b0, sq_l} + {1'b0, sq_t};
	assign sum_tr = {1'b0, sq_r} + {1'b0, sq_t};
	assign sum_bl = {1'b0, sq_l} + {1'b0, sq_b};
	assign sum_br = {1'b0, sq_r} + {1'b0, sq_b};
	assign rsq_e  = {1'b0, cfg.radius_sq};

	assign drop_tl = cfg.corner_mask[0] && near_l && near_t && (sum_tl > rsq_e);
	assign drop_tr = cfg.corner_mask[1] && near_r && near_t && (sum_tr > rsq_e);
	assign drop_bl = cfg.corner_mask[2] && near_l && near_b && (sum_bl > rsq_e);
	assign drop_br = cfg.corner_mask[3] && near_r && near_b && (sum_br > rsq_e);

	assign cov = in_rect && !(drop_tl || drop_tr || drop_bl || drop_br);

	assign addr_full = {{(MUL_W-PIX_W){1'b0}}, pix.pixel_y} * MUL_W'(FB_WIDTH)
		+ {{(MUL_W-PIX_W){1'b0}}, pix.pixel_x};

	always_comb begin
		res.write_enable  = cov;
		res.pixel_address = cov ? addr_full[ADDR_W-1:0] : '0;
		res.pixel_color   = cov ? cfg.fill_color : '0;
	end

endmodule

/* hw/rtl/rounded_rect_fill_coverage.sv */
// Rounded rectangle fill coverage. Each pixel coordinate word gives one result
// word: a write enable, the linear address y * FB_WIDTH + x and the fill color,
// with address and color zero for pixels that are not covered. One pixel is
// taken every clock while results are taken. An accepted pixel is held in
// the input register, and its result is loaded into the result register
// and offered from there. The coverage logic between the two registers (edge
// tests plus four 12x12 squarers for the corner arcs) is combinational and sets
// only the clock period. A result that is not taken holds the result register,
// and once the input register is also full, pix_ready drops until the result is
// taken. Registers are written through the config channel, which is always
// ready. The user must write them only while no pixel is in flight; the block
// does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rounded_rect_fill_coverage
	import rrf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  pix_t                   pix,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_t                   res
);

	cfg_t cfg;
	pix_t pix_s1;
	logic valid_s1;
	res_t res_comb;
	res_t res_s2;
	logic valid_s2;
	logic adv;

	rrf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rrf_cover u_cover (
		.cfg (cfg),
		.pix (pix_s1),
		.res (res_comb)
	);

	// The result register moves whenever it is empty or its word is taken.
	assign adv       = !valid_s2 || res_ready;
	assign pix_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pix_ready) begin
				valid_s1 <= pix_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pix_s1 <= pix;
		end
		if (adv && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	`RRF_ASSERT(a_uncovered_clear, clk, arst_n, (res_valid && !res.write_enable) |-> (res.pixel_address == '0 && res.pixel_color == '0))
	`RRF_ASSERT(a_stage_moves, clk, arst_n, (valid_s1 && adv) |=> res_valid)
	`RRF_ASSERT(a_ready_unless_stalled, clk, arst_n, (!res_valid || res_ready) |-> pix_ready)

endmodule
